// ----- rtl/stress_utilization_color_ramp_defines.svh -----
// ----------------------------------------------------------------------------
// Colour ramp assertion macros
// Concurrent check wrappers, empty when synthesised.
// ----------------------------------------------------------------------------
`ifndef STRESS_UTILIZATION_COLOR_RAMP_DEFINES_SVH
`define STRESS_UTILIZATION_COLOR_RAMP_DEFINES_SVH

`ifndef SYNTHESIS
`define CRM_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("colour ramp check failed");
`define CRM_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("colour ramp sequence check failed");
`else
`define CRM_ASSERT(lbl, clk, rstn, prop)
`define CRM_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// ----- rtl/crm_pkg.sv -----
// ----------------------------------------------------------------------------
// Colour ramp package
// Shared sizes, codes and word types of the colour ramp.
// ----------------------------------------------------------------------------
package crm_pkg;

  localparam int unsigned MaxStops = 16;
  localparam int unsigned IdxW     = $clog2(MaxStops);
  localparam int unsigned CntW     = $clog2(MaxStops + 1);
  localparam int unsigned PosW     = 32;
  localparam int unsigned ColW     = 24;
  localparam int unsigned ChW      = 8;
  localparam int unsigned DivNumW  = 48;
  localparam int unsigned DivDenW  = 33;

  localparam logic [ColW-1:0] GrayColour    = 24'h808080;
  localparam logic [ColW-1:0] ResetOverflow = 24'hFF0000;

  typedef enum logic [1:0] {
    OpLoad = 2'd0,
    OpRamp = 2'd1,
    OpUtil = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    SrcGray     = 3'd0,
    SrcFirst    = 3'd1,
    SrcInterp   = 3'd2,
    SrcLast     = 3'd3,
    SrcOverflow = 3'd4
  } src_e;

  typedef enum logic [1:0] {
    CfgAllow    = 2'd0,
    CfgCount    = 2'd1,
    CfgOverflow = 2'd2
  } cfg_e;

  typedef struct packed {
    logic [PosW-1:0] pos;
    logic [ColW-1:0] col;
  } stop_t;

  typedef struct packed {
    logic            valid;
    logic [PosW-1:0] t;
    logic [CntW-1:0] cnt;
    logic            found;
    stop_t           lo;
    stop_t           hi;
    logic [ColW-1:0] first;
    logic [ColW-1:0] last;
  } qry_t;

  typedef struct packed {
    logic               start;
    logic [DivNumW-1:0] num;
    logic [DivDenW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ----- rtl/crm_div.sv -----
// ----------------------------------------------------------------------------
// Colour ramp divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module crm_div import crm_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  div_req_t           req_i,
  output div_stat_t          stat_o,
  output logic [DivNumW-1:0] quot_o,
  output logic [DivDenW-1:0] rem_o
);

  localparam int unsigned StepW = $clog2(DivNumW + 1);
  localparam logic [StepW-1:0] Steps = StepW'(DivNumW);

  logic [DivNumW-1:0] quot_q, quot_d;
  logic [DivDenW-1:0] rem_q, rem_d;
  logic [DivDenW-1:0] den_q;
  logic [StepW-1:0]   cnt_q;
  logic               busy_q, done_q;
  logic [DivDenW:0]   trial;
  logic               ge;

  always_comb begin
    trial  = {rem_q, quot_q[DivNumW-1]};
    ge     = trial >= {1'b0, den_q};
    rem_d  = ge ? DivDenW'(trial - {1'b0, den_q}) : trial[DivDenW-1:0];
    quot_d = {quot_q[DivNumW-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= Steps;
      end else if (busy_q) begin
        cnt_q <= cnt_q - StepW'(1);
        if (cnt_q == StepW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quot_q <= req_i.num;
      rem_q  <= '0;
      den_q  <= req_i.den;
    end else if (busy_q) begin
      quot_q <= quot_d;
      rem_q  <= rem_d;
    end
  end

  assign stat_o = '{busy: busy_q, done: done_q};
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

endmodule

// ----- rtl/crm_cell.sv -----
// ----------------------------------------------------------------------------
// Colour ramp stop cell
// Holds one colour stop and tests the passing query word against it.
// ----------------------------------------------------------------------------
module crm_cell import crm_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [IdxW-1:0] cell_idx_i,
  input  logic            wr_en_i,
  input  stop_t           wr_stop_i,
  input  stop_t           prev_stop_i,
  output stop_t           stop_o,
  input  qry_t            qry_i,
  output qry_t            qry_o
);

  stop_t           stop_q;
  qry_t            qry_q, qry_d;
  logic [CntW-1:0] idx;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      stop_q <= wr_stop_i;
    end
  end

  always_comb begin
    idx   = CntW'(cell_idx_i);
    qry_d = qry_i;
    if (idx == '0) begin
      qry_d.first = stop_q.col;
    end
    if (idx + CntW'(1) == qry_i.cnt) begin
      qry_d.last = stop_q.col;
    end
    if (!qry_i.found && idx != '0 && idx < qry_i.cnt && qry_i.t <= stop_q.pos) begin
      qry_d.found = 1'b1;
      qry_d.lo    = prev_stop_i;
      qry_d.hi    = stop_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qry_q <= '0;
    end else begin
      qry_q <= qry_d;
    end
  end

  assign stop_o = stop_q;
  assign qry_o  = qry_q;

endmodule

// ----- rtl/stress_utilization_color_ramp.sv -----
// ----------------------------------------------------------------------------
// Stress utilisation colour ramp
// Piecewise linear colour ramp over a row of stop cells, with utilisation.
// ----------------------------------------------------------------------------
// One word at a time. A stop load writes its slot's cell when taken. A ramp
// word walks the row of MaxStops stop cells; a gray, first, last or zero-span
// result leaves once the word comes out of the row. When the word lands
// between two stops, three channel interpolations follow through one shared
// bit-serial divider of 48 steps. A utilisation word first passes through the
// same divider forming the Q16.16 ratio and then walks the row; an overflow
// result leaves in the next cycle. Input stalls while a word is in work or a
// result waits.
// ----------------------------------------------------------------------------
`include "stress_utilization_color_ramp_defines.svh"

module stress_utilization_color_ramp import crm_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [1:0]      op_i,
  input  logic [3:0]      stop_slot_i,
  input  logic [31:0]     stop_position_i,
  input  logic [7:0]      stop_red_i,
  input  logic [7:0]      stop_green_i,
  input  logic [7:0]      stop_blue_i,
  input  logic [31:0]     value_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [7:0]      red_o,
  output logic [7:0]      green_o,
  output logic [7:0]      blue_o,
  output logic [2:0]      source_o,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [1:0]      cfg_index_i,
  input  logic [31:0]     cfg_data_i
);

  localparam int unsigned ProdW = ChW + 1 + PosW + 1;
  localparam int unsigned NumW  = ProdW + 2;

  typedef enum logic [2:0] {
    StIdle, StUdiv, StSearch, StMul, StPrep, StIdiv
  } state_e;

  function automatic logic [ChW-1:0] col_chan(input logic [ColW-1:0] col,
                                             input logic [1:0] ch);
    logic [ChW-1:0] r;
    case (ch)
      2'd0:    r = col[23:16];
      2'd1:    r = col[15:8];
      default: r = col[7:0];
    endcase
    return r;
  endfunction

  state_e          state_q;
  logic [31:0]     allow_q;
  logic [4:0]      count_q;
  logic [ColW-1:0] ovf_q;
  logic            out_valid_q;
  logic [ChW-1:0]  red_q, green_q, blue_q;
  logic [2:0]      src_q;
  logic            launch_q;
  logic [PosW-1:0] t_q;
  qry_t            res_q;
  logic [PosW-1:0] s_q;
  logic signed [PosW:0]    d_q;
  logic [1:0]              ch_q;
  logic signed [ProdW-1:0] prod_q;
  logic                    neg_q;
  logic               div_start_q;
  logic [DivNumW-1:0] div_num_q;
  logic [DivDenW-1:0] div_den_q;
  div_req_t           div_req;
  div_stat_t       div_stat;
  logic [DivNumW-1:0] div_quot;
  logic [DivDenW-1:0] div_rem;

  logic            accept;
  logic [CntW-1:0] n_eff;
  logic [31:0]     den_c;
  logic [MaxStops-1:0] wr_en;
  stop_t           wr_stop;
  stop_t           cell_stop [MaxStops];
  qry_t            cell_qry  [MaxStops];
  qry_t            qry_in;
  qry_t            chain_out;

  logic signed [PosW:0]    span_c, dist_c;
  logic signed [ChW:0]     diff_c;
  logic signed [ProdW-1:0] prod_c;
  logic signed [NumW-1:0]  num_c, mag_c;
  logic [DivNumW:0]        qmag_c;
  logic [9:0]              qclip_c;
  logic signed [10:0]      sq_c;
  logic signed [11:0]      v_c;
  logic [ChW-1:0]          vch_c;
  logic [ChW-1:0]          a_c, b_c;

  assign accept      = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != StIdle) || out_valid_q;
  assign cfg_ready_o = 1'b1;
  assign n_eff       = (32'(count_q) > MaxStops) ? CntW'(MaxStops) : CntW'(count_q);
  assign den_c       = (allow_q == '0) ? 32'd1 : allow_q;
  assign wr_stop     = '{pos: stop_position_i, col: {stop_red_i, stop_green_i, stop_blue_i}};
  assign div_req     = '{start: div_start_q, num: div_num_q, den: div_den_q};

  always_comb begin
    for (int i = 0; i < MaxStops; i++) begin
      wr_en[i] = accept && (op_i == OpLoad) && (32'(stop_slot_i) == i);
    end
  end

  always_comb begin
    qry_in       = '0;
    qry_in.valid = launch_q;
    qry_in.t     = t_q;
    qry_in.cnt   = n_eff;
  end

  for (genvar g = 0; g < MaxStops; g++) begin : g_cell
    crm_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .cell_idx_i  (IdxW'(g)),
      .wr_en_i     (wr_en[g]),
      .wr_stop_i   (wr_stop),
      .prev_stop_i ((g == 0) ? stop_t'('0) : cell_stop[(g == 0) ? 0 : g - 1]),
      .stop_o      (cell_stop[g]),
      .qry_i       ((g == 0) ? qry_in : cell_qry[(g == 0) ? 0 : g - 1]),
      .qry_o       (cell_qry[g])
    );
  end

  assign chain_out = cell_qry[MaxStops-1];

  crm_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .stat_o (div_stat),
    .quot_o (div_quot),
    .rem_o  (div_rem)
  );

  always_comb begin
    span_c  = $signed({1'b0, chain_out.hi.pos}) - $signed({1'b0, chain_out.lo.pos});
    dist_c  = $signed({1'b0, chain_out.t}) - $signed({1'b0, chain_out.lo.pos});
    a_c     = col_chan(res_q.lo.col, ch_q);
    b_c     = col_chan(res_q.hi.col, ch_q);
    diff_c  = $signed({1'b0, b_c}) - $signed({1'b0, a_c});
    prod_c  = diff_c * d_q;
    num_c   = $signed({prod_q[ProdW-1], prod_q, 1'b0})
            + $signed({{(NumW-PosW){1'b0}}, s_q});
    mag_c   = (num_c < 0) ? -num_c : num_c;
    qmag_c  = {1'b0, div_quot} + (DivNumW+1)'(neg_q && (div_rem != '0));
    qclip_c = (qmag_c > (DivNumW+1)'(511)) ? 10'd512 : qmag_c[9:0];
    sq_c    = neg_q ? -$signed({1'b0, qclip_c}) : $signed({1'b0, qclip_c});
    v_c     = $signed({4'b0000, a_c}) + $signed({sq_c[10], sq_c});
    if (v_c < 0) begin
      vch_c = '0;
    end else if (v_c > 12'sd255) begin
      vch_c = 8'd255;
    end else begin
      vch_c = v_c[ChW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      allow_q <= 32'd1;
      count_q <= '0;
      ovf_q   <= ResetOverflow;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CfgAllow:    allow_q <= cfg_data_i;
        CfgCount:    count_q <= cfg_data_i[4:0];
        CfgOverflow: ovf_q   <= cfg_data_i[ColW-1:0];
        default:     ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
      launch_q    <= 1'b0;
      div_start_q <= 1'b0;
    end else begin
      launch_q    <= 1'b0;
      div_start_q <= 1'b0;
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (accept) begin
            case (op_i)
              OpRamp: begin
                launch_q <= 1'b1;
                state_q  <= StSearch;
              end
              OpUtil: begin
                if (value_i > den_c) begin
                  out_valid_q <= 1'b1;
                end else begin
                  div_start_q <= 1'b1;
                  state_q     <= StUdiv;
                end
              end
              default: ;
            endcase
          end
        end
        StUdiv: begin
          if (div_stat.done) begin
            launch_q <= 1'b1;
            state_q  <= StSearch;
          end
        end
        StSearch: begin
          if (chain_out.valid) begin
            if (chain_out.cnt != '0 && chain_out.t != '0 && chain_out.found
                && span_c != 0) begin
              state_q <= StMul;
            end else begin
              out_valid_q <= 1'b1;
              state_q     <= StIdle;
            end
          end
        end
        StMul:  state_q <= StPrep;
        StPrep: begin
          div_start_q <= 1'b1;
          state_q     <= StIdiv;
        end
        StIdiv: begin
          if (div_stat.done) begin
            if (ch_q == 2'd2) begin
              out_valid_q <= 1'b1;
              state_q     <= StIdle;
            end else begin
              state_q <= StMul;
            end
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      StIdle: begin
        if (accept) begin
          t_q <= value_i;
          if (op_i == OpUtil) begin
            red_q     <= ovf_q[23:16];
            green_q   <= ovf_q[15:8];
            blue_q    <= ovf_q[7:0];
            src_q     <= SrcOverflow;
            div_num_q <= {value_i, 16'h0000};
            div_den_q <= {1'b0, den_c};
          end
        end
      end
      StUdiv: begin
        if (div_stat.done) begin
          t_q <= div_quot[PosW-1:0];
        end
      end
      StSearch: begin
        if (chain_out.valid) begin
          res_q <= chain_out;
          ch_q  <= 2'd0;
          s_q   <= (span_c < 0) ? PosW'(-span_c) : span_c[PosW-1:0];
          d_q   <= (span_c < 0) ? -dist_c : dist_c;
          if (chain_out.cnt == '0) begin
            {red_q, green_q, blue_q} <= GrayColour;
            src_q <= SrcGray;
          end else if (chain_out.t == '0) begin
            {red_q, green_q, blue_q} <= chain_out.first;
            src_q <= SrcFirst;
          end else if (!chain_out.found) begin
            {red_q, green_q, blue_q} <= chain_out.last;
            src_q <= SrcLast;
          end else begin
            {red_q, green_q, blue_q} <= chain_out.lo.col;
            src_q <= SrcInterp;
          end
        end
      end
      StMul: prod_q <= prod_c;
      StPrep: begin
        neg_q     <= num_c < 0;
        div_num_q <= {{(DivNumW-NumW){1'b0}}, mag_c};
        div_den_q <= {s_q, 1'b0};
      end
      StIdiv: begin
        if (div_stat.done) begin
          case (ch_q)
            2'd0:    red_q   <= vch_c;
            2'd1:    green_q <= vch_c;
            default: blue_q  <= vch_c;
          endcase
          ch_q <= ch_q + 2'd1;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign red_o       = red_q;
  assign green_o     = green_q;
  assign blue_o      = blue_q;
  assign source_o    = src_q;

  `CRM_ASSERT(a_chain_in_search, clk_i, rst_ni, chain_out.valid |-> state_q == StSearch)
  `CRM_ASSERT(a_div_owner, clk_i, rst_ni, div_stat.busy |-> (state_q == StUdiv || state_q == StIdiv))
  `CRM_ASSERT(a_one_slot, clk_i, rst_ni, $onehot0(wr_en))
  `CRM_ASSERT_NEXT(a_ramp_walks, clk_i, rst_ni, accept && op_i == OpRamp, state_q == StSearch && launch_q)

endmodule
